>>> sv/mrg_pkg.sv
// shared types and constants for the interval merge unit
package mrg_pkg;
  localparam int DATA_W          = 16;
  localparam int DIGIT_W         = 4;
  localparam int RADIX           = 16;
  localparam int PASSES          = 4;
  localparam int MAX_INTERVALS_D = 64;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic [DATA_W-1:0] start_value;
    logic [DATA_W-1:0] end_value;
    logic              last_in;
    logic              keep;
    logic              dropped;
  } req_t;
endpackage

>>> sv/mrg_front.sv
// front end: counts requests, marks those beyond capacity and the set's drop state
module mrg_front import mrg_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] start_value,
  input  logic [DATA_W-1:0] end_value,
  input  logic              last_in,
  output logic              q_push,
  output req_t              q_req,
  input  logic              q_full
);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  logic [CW-1:0] count;
  logic          dropped;
  logic          keep;

  assign keep     = count < CW'(MAX_INTERVALS);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.start_value = start_value;
    q_req.end_value   = end_value;
    q_req.last_in     = last_in;
    q_req.keep        = keep;
    q_req.dropped     = dropped || !keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (q_push) begin
      if (last_in) begin
        count   <= '0;
        dropped <= 1'b0;
      end else begin
        if (keep) count <= count + CW'(1);
        else dropped <= 1'b1;
      end
    end
  end
endmodule

>>> sv/mrg_queue.sv
// short request queue between front and back
module mrg_queue import mrg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output req_t head,
  output logic head_valid
);
  localparam int PW = $clog2(QUEUE_DEPTH);

  req_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full       = fill == (PW+1)'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

>>> sv/mrg_back.sv
// back end: store, radix sort by start, merge walk and output register
module mrg_back import mrg_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D
) (
  input  logic              clk,
  input  logic              rst,
  input  req_t              head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] merged_start,
  output logic [DATA_W-1:0] merged_end,
  output logic              last_out,
  output logic              overflow
);
  localparam int CW  = $clog2(MAX_INTERVALS + 1);
  localparam int AW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int KW  = $clog2(RADIX);
  localparam int PSW = $clog2(PASSES);
  localparam int EW  = 2 * DATA_W;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_CNT  = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_SCT  = 3'd3;
  localparam logic [2:0] ST_MRD  = 3'd4;
  localparam logic [2:0] ST_MEX  = 3'd5;
  localparam logic [2:0] ST_MFIN = 3'd6;

  logic [EW-1:0]  mem_a [MAX_INTERVALS];
  logic [EW-1:0]  mem_b [MAX_INTERVALS];
  logic [EW-1:0]  rda, rdb, rdata;
  logic [CW-1:0]  counts [RADIX];
  logic [2:0]     state;
  logic [CW-1:0]  n;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  sum;
  logic [KW-1:0]  k;
  logic [PSW-1:0] pass;
  logic           src_b;
  logic           rvld;
  logic           first;
  logic           dropped;
  logic [EW-1:0]  cur;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [KW-1:0]  digit;
  logic [DATA_W-1:0] rd_start, rd_end, cur_end;
  logic           out_free;
  logic           emit;
  logic           wr_a, wr_b;
  logic [AW-1:0]  wr_addr;
  logic [CW-1:0]  pos;

  assign rdata    = src_b ? rdb : rda;
  assign rd_start = rdata[EW-1:DATA_W];
  assign rd_end   = rdata[DATA_W-1:0];
  assign cur_end  = cur[DATA_W-1:0];
  assign digit    = rd_start[{pass, 2'b00} +: DIGIT_W];
  assign pos      = counts[digit];
  assign out_free = !out_valid || out_ready;
  assign rd_addr  = idx[AW-1:0];
  assign pop      = (state == ST_LOAD) && head_valid;
  assign emit     = out_free && ((state == ST_MFIN) ||
                    (state == ST_MEX && !first && (rd_start > cur_end)));

  always_comb begin
    rd_en = 1'b0;
    if ((state == ST_CNT || state == ST_SCT || state == ST_MRD) && idx < n) rd_en = 1'b1;
  end

  always_comb begin
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    wr_addr = pos[AW-1:0];
    if (state == ST_LOAD) begin
      wr_a    = pop && head.keep;
      wr_addr = n[AW-1:0];
    end else if (state == ST_SCT && rvld) begin
      wr_a = src_b;
      wr_b = !src_b;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[wr_addr] <= (state == ST_LOAD) ? {head.start_value, head.end_value} : rdata;
    if (wr_b) mem_b[wr_addr] <= rdata;
    if (rd_en) begin
      rda <= mem_a[rd_addr];
      rdb <= mem_b[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      n         <= '0;
      idx       <= '0;
      sum       <= '0;
      k         <= '0;
      pass      <= '0;
      src_b     <= 1'b0;
      rvld      <= 1'b0;
      first     <= 1'b1;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < RADIX; i++) counts[i] <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      rvld <= rd_en;
      if (rd_en) idx <= idx + CW'(1);
      unique case (state)
        ST_LOAD: begin
          if (pop) begin
            if (head.keep) n <= n + CW'(1);
            if (head.last_in) begin
              dropped <= head.dropped;
              state   <= ST_CNT;
              idx     <= '0;
              pass    <= '0;
              src_b   <= 1'b0;
              for (int i = 0; i < RADIX; i++) counts[i] <= '0;
            end
          end
        end
        ST_CNT: begin
          if (rvld) counts[digit] <= counts[digit] + CW'(1);
          if (!rd_en && !rvld) begin
            state <= ST_PRE;
            k     <= '0;
            sum   <= '0;
          end
        end
        ST_PRE: begin
          counts[k] <= sum;
          sum       <= sum + counts[k];
          k         <= k + KW'(1);
          if (k == KW'(RADIX - 1)) begin
            state <= ST_SCT;
            idx   <= '0;
          end
        end
        ST_SCT: begin
          if (rvld) counts[digit] <= counts[digit] + CW'(1);
          if (!rd_en && !rvld) begin
            src_b <= !src_b;
            pass  <= pass + PSW'(1);
            idx   <= '0;
            for (int i = 0; i < RADIX; i++) counts[i] <= '0;
            if (pass == PSW'(PASSES - 1)) begin
              state <= ST_MRD;
              first <= 1'b1;
            end else begin
              state <= ST_CNT;
            end
          end
        end
        ST_MRD: begin
          if (rd_en) state <= ST_MEX;
          else state <= ST_MFIN;
        end
        ST_MEX: begin
          if (first) begin
            cur   <= rdata;
            first <= 1'b0;
            state <= ST_MRD;
          end else if (rd_start <= cur_end) begin
            if (rd_end > cur_end) cur[DATA_W-1:0] <= rd_end;
            state <= ST_MRD;
          end else if (out_free) begin
            merged_start <= cur[EW-1:DATA_W];
            merged_end   <= cur_end;
            last_out     <= 1'b0;
            overflow     <= dropped;
            cur          <= rdata;
            state        <= ST_MRD;
          end
        end
        ST_MFIN: begin
          if (out_free) begin
            merged_start <= cur[EW-1:DATA_W];
            merged_end   <= cur_end;
            last_out     <= 1'b1;
            overflow     <= dropped;
            n            <= '0;
            state        <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

>>> sv/merge_overlapping_intervals_unit.sv
// top level of the interval merge unit
//  channel | dir | tdata                         | tlast    | tuser
//  s_axis  | in  | start_value, end_value        | last_in  | -
//  m_axis  | out | merged_start, merged_end      | last_out | overflow
// loading takes one request per cycle while the queue holds requests; the set ends at the request with tlast
// sorting runs four radix-16 passes over the store memories, each a count,
// prefix sum and scatter step, then the merge walk reads each stored interval in turn
// requests queue up during the sort and stall once the queue is full
// the output register stalls the merge walk only while a result waits
// reset is synchronous and clears all control state
module merge_overlapping_intervals_unit import mrg_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // start_value, end_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // merged_start, merged_end
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // overflow
);
  logic q_push, q_full, pop, head_valid;
  req_t q_req, head;

  mrg_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .start_value(s_axis_tdata[15:0]), .end_value(s_axis_tdata[31:16]),
    .last_in(s_axis_tlast),
    .q_push(q_push), .q_req(q_req), .q_full(q_full)
  );

  mrg_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_req(q_req), .full(q_full),
    .pop(pop), .head(head), .head_valid(head_valid)
  );

  mrg_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk(clk), .rst(rst),
    .head(head), .head_valid(head_valid), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .merged_start(m_axis_tdata[15:0]), .merged_end(m_axis_tdata[31:16]),
    .last_out(m_axis_tlast), .overflow(m_axis_tuser)
  );

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last_in) |=> !pop)
    else $error("back took a request right after the end of a set");

  a_drop_marked: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.keep) |-> head.dropped)
    else $error("dropped request not flagged");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
endmodule
